FILE: rtl/bsld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsld_pkg: shared definitions for the bounded squared distance block
// Element, lane and accumulator widths, the input word layout, and the
// register map of the configuration port.
// ----------------------------------------------------------------------------
package bsld_pkg;

    localparam int LANES         = 4;
    localparam int ELEM_BITS     = 16;
    localparam int ACC_BITS      = 48;
    localparam int LANE_CNT_BITS = $clog2(LANES + 1);

    // A lane square is exact in twice the element width, since |a - b| fits
    // in ELEM_BITS unsigned bits.
    localparam int SQ_BITS       = 2 * ELEM_BITS;
    localparam int ITEM_SUM_BITS = SQ_BITS + $clog2(LANES);

    localparam int APB_DATA_BITS = 64;
    localparam int APB_ADDR_BITS = 4;

    typedef logic [0:0] reg_idx_t;
    localparam reg_idx_t REG_DISTANCE_BOUND = 1'b0;

    localparam logic [ACC_BITS-1:0] ACC_MAX = '1;

    typedef logic signed [ELEM_BITS-1:0] elem_t;

    typedef struct packed {
        elem_t [LANES-1:0]        a;
        elem_t [LANES-1:0]        b;
        logic [LANE_CNT_BITS-1:0] lanes_valid;
        logic                     last;
    } item_t;

endpackage

FILE: rtl/bsld_lane_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsld_lane_sum: lane squares and their sum
// Forms a - b in every lane, squares its magnitude, and adds the squares of
// the valid lanes into one exact word sum.
// ----------------------------------------------------------------------------
module bsld_lane_sum (
    input  bsld_pkg::item_t                        item,
    output logic [bsld_pkg::ITEM_SUM_BITS-1:0]     item_sum
);
    import bsld_pkg::*;

    logic signed [ELEM_BITS:0] diff [LANES];
    logic [ELEM_BITS-1:0]      mag  [LANES];
    logic [SQ_BITS-1:0]        sq   [LANES];

    always_comb
    begin
        item_sum = '0;
        for (int k = 0; k < LANES; k++)
        begin
            diff[k] = {item.a[k][ELEM_BITS-1], item.a[k]}
                    - {item.b[k][ELEM_BITS-1], item.b[k]};
            mag[k]  = diff[k][ELEM_BITS] ? ELEM_BITS'(-diff[k])
                                         : diff[k][ELEM_BITS-1:0];
            sq[k]   = mag[k] * mag[k];
            // Lane counts above LANES cover every lane, which saturates them.
            if (LANE_CNT_BITS'(k) < item.lanes_valid)
            begin
                item_sum = item_sum + ITEM_SUM_BITS'(sq[k]);
            end
        end
    end

endmodule

FILE: rtl/bounded_squared_l2_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_squared_l2_distance: streaming squared distance with early exit
// Accumulates squared lane differences of two vectors against a bound and
// reports the distance and an exceeded flag on the last word of a vector.
// ----------------------------------------------------------------------------
// The block takes one word per cycle, each carrying up to four element pairs
// and a count of valid lanes, and sustains that rate for any mix of words
// while the input does not stall. A word passes three registered steps: the
// input register, the lane square and sum register, and the accumulator with
// the result register. The loop around the 48-bit saturating add and bound
// compare is what sets the rate of one word per cycle. Once the running sum
// exceeds distance_bound (written over the APB port at byte address 0), the
// sum freezes and exceeded is reported with the word marked last, after which
// the sum and flag return to zero. The input only stalls when a last word
// must leave the square stage while an earlier result still waits.
// ----------------------------------------------------------------------------
module bounded_squared_l2_distance (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Configuration port.
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [bsld_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  logic [bsld_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [bsld_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                   pready,
    // Input words.
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [bsld_pkg::ELEM_BITS-1:0]  a_lane0,
    input  logic signed [bsld_pkg::ELEM_BITS-1:0]  a_lane1,
    input  logic signed [bsld_pkg::ELEM_BITS-1:0]  a_lane2,
    input  logic signed [bsld_pkg::ELEM_BITS-1:0]  a_lane3,
    input  logic signed [bsld_pkg::ELEM_BITS-1:0]  b_lane0,
    input  logic signed [bsld_pkg::ELEM_BITS-1:0]  b_lane1,
    input  logic signed [bsld_pkg::ELEM_BITS-1:0]  b_lane2,
    input  logic signed [bsld_pkg::ELEM_BITS-1:0]  b_lane3,
    input  logic [bsld_pkg::LANE_CNT_BITS-1:0]     lanes_valid,
    input  logic                                   last,
    // Result words.
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [bsld_pkg::ACC_BITS-1:0]          distance,
    output logic                                   exceeded
);
    import bsld_pkg::*;

    // Configuration register.
    logic [ACC_BITS-1:0]      bound_reg, bound_next;
    reg_idx_t                 reg_index;
    logic                     cfg_write;

    // Input register stage.
    logic                     s0_valid_reg, s0_valid_next;
    item_t                    s0_item_reg;
    item_t                    in_item;

    // Square and sum stage.
    logic                     s1_valid_reg, s1_valid_next;
    logic                     s1_last_reg, s1_last_next;
    logic [ITEM_SUM_BITS-1:0] s1_sum_reg;
    logic [ITEM_SUM_BITS-1:0] lane_sum;

    // Accumulator and result register.
    logic [ACC_BITS-1:0]      running_sum_reg, running_sum_next;
    logic                     over_bound_reg, over_bound_next;
    logic                     out_valid_reg, out_valid_next;
    logic [ACC_BITS-1:0]      distance_reg, distance_next;
    logic                     exceeded_reg, exceeded_next;

    logic                     block;
    logic                     adv1;
    logic                     load1;
    logic                     accept;
    logic [ACC_BITS:0]        acc_sum;
    logic [ACC_BITS-1:0]      acc_sat;
    logic [ACC_BITS-1:0]      new_sum;
    logic                     new_over;

    // ------------------------------------------------------------------
    // Configuration port. Writes complete in the access cycle; the
    // register index is taken from the 8-byte word address.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_index = paddr[APB_ADDR_BITS-1];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        bound_next = bound_reg;
        if (cfg_write && (reg_index == REG_DISTANCE_BOUND))
        begin
            bound_next = pwdata[ACC_BITS-1:0];
        end
        if (reg_index == REG_DISTANCE_BOUND)
        begin
            prdata = APB_DATA_BITS'(bound_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    // ------------------------------------------------------------------
    // Flow control. Only a last word in the square stage needs the result
    // register; any other word moves into the accumulator every cycle.
    // ------------------------------------------------------------------
    assign block    = s1_valid_reg && s1_last_reg && out_valid_reg && !out_ready;
    assign adv1     = s1_valid_reg && !block;
    assign load1    = s0_valid_reg && (!s1_valid_reg || !block);
    assign in_ready = !s0_valid_reg || load1;
    assign accept   = in_valid && in_ready;

    assign in_item.a[0]        = a_lane0;
    assign in_item.a[1]        = a_lane1;
    assign in_item.a[2]        = a_lane2;
    assign in_item.a[3]        = a_lane3;
    assign in_item.b[0]        = b_lane0;
    assign in_item.b[1]        = b_lane1;
    assign in_item.b[2]        = b_lane2;
    assign in_item.b[3]        = b_lane3;
    assign in_item.lanes_valid = lanes_valid;
    assign in_item.last        = last;

    bsld_lane_sum u_lane_sum (
        .item     (s0_item_reg),
        .item_sum (lane_sum)
    );

    always_comb
    begin
        s0_valid_next = s0_valid_reg;
        if (accept)
        begin
            s0_valid_next = 1'b1;
        end
        else if (load1)
        begin
            s0_valid_next = 1'b0;
        end

        s1_valid_next = s1_valid_reg;
        s1_last_next  = s1_last_reg;
        if (load1)
        begin
            s1_valid_next = 1'b1;
            s1_last_next  = s0_item_reg.last;
        end
        else if (adv1)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Accumulator. The word sum is added with saturation and checked
    // against the bound with a strict greater-than. While the flag is set
    // the sum holds its value. A last word writes the result register and
    // returns the accumulator to zero.
    // ------------------------------------------------------------------
    always_comb
    begin
        acc_sum = {1'b0, running_sum_reg} + (ACC_BITS + 1)'(s1_sum_reg);
        acc_sat = acc_sum[ACC_BITS] ? ACC_MAX : acc_sum[ACC_BITS-1:0];

        if (over_bound_reg)
        begin
            new_sum  = running_sum_reg;
            new_over = 1'b1;
        end
        else
        begin
            new_sum  = acc_sat;
            new_over = acc_sat > bound_reg;
        end

        running_sum_next = running_sum_reg;
        over_bound_next  = over_bound_reg;
        distance_next    = distance_reg;
        exceeded_next    = exceeded_reg;
        out_valid_next   = out_valid_reg && !out_ready;

        if (adv1)
        begin
            if (s1_last_reg)
            begin
                distance_next    = new_sum;
                exceeded_next    = new_over;
                out_valid_next   = 1'b1;
                running_sum_next = '0;
                over_bound_next  = 1'b0;
            end
            else
            begin
                running_sum_next = new_sum;
                over_bound_next  = new_over;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_reg       <= ACC_MAX;
            s0_valid_reg    <= 1'b0;
            s1_valid_reg    <= 1'b0;
            s1_last_reg     <= 1'b0;
            running_sum_reg <= '0;
            over_bound_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            bound_reg       <= bound_next;
            s0_valid_reg    <= s0_valid_next;
            s1_valid_reg    <= s1_valid_next;
            s1_last_reg     <= s1_last_next;
            running_sum_reg <= running_sum_next;
            over_bound_reg  <= over_bound_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_item_reg <= in_item;
        end
        if (load1)
        begin
            s1_sum_reg <= lane_sum;
        end
        distance_reg <= distance_next;
        exceeded_reg <= exceeded_next;
    end

    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;
    assign exceeded  = exceeded_reg;

`ifndef NO_ASSERTIONS
    // A last word that leaves the square stage always produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv1 && s1_last_reg) |=> out_valid_reg)
    else $error("last word did not produce a result");

    // The accumulator is clear after a vector ends.
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv1 && s1_last_reg) |=> (running_sum_reg == '0) && !over_bound_reg)
    else $error("accumulator not cleared after last word");

    // Once the bound is exceeded the sum stays frozen until the vector ends.
    assert property (@(posedge clk) disable iff (!rst_n)
        (over_bound_reg && !(adv1 && s1_last_reg)) |=> $stable(running_sum_reg))
    else $error("frozen sum changed");

    // The input only stalls when both stages and the result register are full
    // and the result is not being taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s0_valid_reg && s1_valid_reg && s1_last_reg
                       && out_valid_reg && !out_ready))
    else $error("input stalled without cause");
`endif

endmodule
